>>> rtl/core/wtes_pkg.sv
// ----------------------------------------------------------------------------
// Tracking error statistics package
// Shared widths, codes and types for the windowed tracking error block.
// ----------------------------------------------------------------------------
package wtes_pkg;

  localparam int ERR_W     = 25;
  localparam int KIND_W    = 3;
  localparam int MODE_W    = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_OUT_W = 11;

  localparam int DEF_MAX_WINDOW = 1024;
  localparam int DEF_COORD_BITS = 24;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_DRONE_POS  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TARGET_POS = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DRONE_VEL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TARGET_VEL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MODE       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TRACKING_MODE_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_ONLY_TRACKING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH        = 2'd2;

  localparam logic [MODE_W-1:0] RST_TRACKING_MODE_CODE = 8'd3;
  localparam logic              RST_RECORD_ONLY        = 1'b1;
  localparam logic [CFG_W-1:0]  RST_WINDOW_LENGTH      = 11'd1000;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_cmd_t;

endpackage

>>> rtl/core/wtes_ring.sv
// ----------------------------------------------------------------------------
// Error ring memory
// Single write port, single registered read port storage for distance errors.
// ----------------------------------------------------------------------------
module wtes_ring #(
  parameter int DEPTH = wtes_pkg::DEF_MAX_WINDOW,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [wtes_pkg::ERR_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [wtes_pkg::ERR_W-1:0] rdata
);

  logic [wtes_pkg::ERR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/wtes_arith.sv
// ----------------------------------------------------------------------------
// Shared divide and square root unit
// Restoring division one quotient bit per cycle, or digit-by-digit integer
// square root one result bit per cycle, through one compare and subtract.
// ----------------------------------------------------------------------------
module wtes_arith #(
  parameter int UW = 64,
  parameter int CW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wtes_pkg::arith_cmd_t cmd,
  input  logic [UW-1:0]        a,
  input  logic [CW-1:0]        b,
  output logic                 done,
  output logic [UW-1:0]        res
);

  localparam int RW = UW / 2 + 3;
  localparam int NW = $clog2(UW + 1);

  logic [UW-1:0]       sh;
  logic [RW-1:0]       rem;
  logic [CW-1:0]       dvs;
  logic [NW-1:0]       cnt;
  logic                busy;
  wtes_pkg::arith_op_t op;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] cmp;
  logic          ge;

  always_comb begin
    if (op == wtes_pkg::OP_SQRT) begin
      rem_sh = {rem[RW-3:0], sh[UW-1:UW-2]};
      cmp    = RW'({res[UW/2-1:0], 2'b01});
    end else begin
      rem_sh = {rem[RW-2:0], sh[UW-1]};
      cmp    = RW'(dvs);
    end
    ge = (rem_sh >= cmp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= wtes_pkg::OP_DIV;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        cnt  <= (cmd.op == wtes_pkg::OP_SQRT) ? NW'(UW / 2) : NW'(UW);
      end else if (busy) begin
        cnt <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sh  <= a;
      dvs <= b;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - cmp) : rem_sh;
      res <= {res[UW-2:0], ge};
      sh  <= (op == wtes_pkg::OP_SQRT) ? {sh[UW-3:0], 2'b00} : {sh[UW-2:0], 1'b0};
    end
  end

endmodule

>>> rtl/core/windowed_tracking_error_stats.sv
// A recorded drone position goes through the rescan of the error ring for
// the maximum and the one-bit-per-cycle divide and square root unit.
// One item at a time; the next is taken while a result waits to be moved.
// Reset is synchronous, clears the window, flags and mode, and sets the
// configuration registers to their reset values.
// ----------------------------------------------------------------------------
// Windowed tracking error statistics
// Distance from drone to target with sliding window mean, max and RMS.
// ----------------------------------------------------------------------------
module windowed_tracking_error_stats #(
  parameter int MAX_WINDOW = wtes_pkg::DEF_MAX_WINDOW,
  parameter int COORD_BITS = wtes_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [wtes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wtes_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wtes_pkg::KIND_W-1:0]       kind,
  input  logic signed [COORD_BITS-1:0]      pos_x,
  input  logic signed [COORD_BITS-1:0]      pos_y,
  input  logic signed [COORD_BITS-1:0]      pos_z,
  input  logic [wtes_pkg::MODE_W-1:0]       mode_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wtes_pkg::ERR_W-1:0]        range_error,
  output logic [wtes_pkg::ERR_W-1:0]        mean_error,
  output logic [wtes_pkg::ERR_W-1:0]        max_error,
  output logic [wtes_pkg::ERR_W-1:0]        rms_error,
  output logic [wtes_pkg::CNT_OUT_W-1:0]    sample_count
);

  localparam int EW  = wtes_pkg::ERR_W;
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = EW + CW;
  localparam int SQW = 2 * EW + CW;
  localparam int UWR = (SQW > 64) ? SQW : 64;
  localparam int UW  = ((UWR + 1) / 2) * 2;
  localparam int DW  = COORD_BITS + 1;

  typedef enum logic [18:0] {
    S_IDLE      = 19'd1 << 0,
    S_MUL       = 19'd1 << 1,
    S_ACC       = 19'd1 << 2,
    S_ROOT      = 19'd1 << 3,
    S_ROOT_WAIT = 19'd1 << 4,
    S_EVCHK     = 19'd1 << 5,
    S_EVRD      = 19'd1 << 6,
    S_EVMUL     = 19'd1 << 7,
    S_EVSUB     = 19'd1 << 8,
    S_WMUL      = 19'd1 << 9,
    S_WRITE     = 19'd1 << 10,
    S_SCAN      = 19'd1 << 11,
    S_MEAN      = 19'd1 << 12,
    S_MEAN_WAIT = 19'd1 << 13,
    S_MSQ       = 19'd1 << 14,
    S_MSQ_WAIT  = 19'd1 << 15,
    S_RMS       = 19'd1 << 16,
    S_RMS_WAIT  = 19'd1 << 17,
    S_DONE      = 19'd1 << 18
  } state_t;

  state_t state, state_next;

  logic [wtes_pkg::MODE_W-1:0] trk_code;
  logic                        rec_only;
  logic [wtes_pkg::CFG_W-1:0]  wlen;

  logic signed [COORD_BITS-1:0] tgt_x, tgt_y, tgt_z;
  logic signed [COORD_BITS-1:0] drn_x, drn_y, drn_z;
  logic [2:0]                   seen;
  logic                         in_trk;
  logic [wtes_pkg::MODE_W-1:0]  cur_mode;

  logic [AW-1:0]  head;
  logic [CW-1:0]  count;
  logic [SW-1:0]  esum;
  logic [SQW-1:0] ssum;
  logic [EW-1:0]  wmax;

  logic [1:0]     idx;
  logic [63:0]    acc;
  logic [63:0]    prod;
  logic [EW-1:0]  err_now;
  logic [EW-1:0]  old_e;
  logic [EW-1:0]  mean_r;
  logic [EW-1:0]  rms_r;
  logic [AW-1:0]  ptr;
  logic [CW-1:0]  issued;
  logic           pend;

  logic [CW-1:0]  win_len;
  logic [AW:0]    slot_sum;
  logic [AW-1:0]  slot;
  logic [AW-1:0]  head_inc;
  logic [AW-1:0]  ptr_inc;

  logic signed [COORD_BITS-1:0] sel_d, sel_t;
  logic signed [DW-1:0]         diff;
  logic [DW-1:0]                adiff;
  logic                         dsat;
  logic [31:0]                  mul_a;
  logic [63:0]                  mul_p;
  logic [64:0]                  acc_sum;

  logic                 accept;
  logic                 record_ok;
  logic                 scan_issue;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        rd_data;
  logic                 wr_en;

  wtes_pkg::arith_cmd_t cmd;
  logic [UW-1:0]        ar_a;
  logic                 ar_done;
  logic [UW-1:0]        ar_res;

  assign accept    = in_valid && (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign record_ok = !(rec_only && !in_trk) && (seen == 3'b111);

  always_comb begin
    if (wlen == '0) begin
      win_len = CW'(1);
    end else if (32'(wlen) > 32'(MAX_WINDOW)) begin
      win_len = CW'(MAX_WINDOW);
    end else begin
      win_len = CW'(wlen);
    end
  end

  always_comb begin
    slot_sum = {1'b0, head} + (AW + 1)'(count);
    if (slot_sum >= (AW + 1)'(MAX_WINDOW)) begin
      slot = AW'(slot_sum - (AW + 1)'(MAX_WINDOW));
    end else begin
      slot = AW'(slot_sum);
    end
    head_inc = (head == AW'(MAX_WINDOW - 1)) ? '0 : head + AW'(1);
    ptr_inc  = (ptr == AW'(MAX_WINDOW - 1)) ? '0 : ptr + AW'(1);
  end

  always_comb begin
    case (idx)
      2'd0: begin
        sel_d = drn_x;
        sel_t = tgt_x;
      end
      2'd1: begin
        sel_d = drn_y;
        sel_t = tgt_y;
      end
      default: begin
        sel_d = drn_z;
        sel_t = tgt_z;
      end
    endcase
    diff  = DW'(sel_d) - DW'(sel_t);
    adiff = diff[DW-1] ? DW'(-diff) : DW'(diff);
    dsat  = (64'(adiff) > 64'hFFFF_FFFF);
  end

  always_comb begin
    case (state)
      S_EVMUL: mul_a = 32'(rd_data);
      S_WMUL:  mul_a = 32'(err_now);
      default: mul_a = 32'(adiff);
    endcase
  end

  assign mul_p   = mul_a * mul_a;
  assign acc_sum = {1'b0, acc} + {1'b0, prod};

  assign scan_issue = (state == S_SCAN) && (issued < count);
  assign rd_en      = (state == S_EVRD) || scan_issue;
  assign rd_addr    = (state == S_EVRD) ? head : ptr;
  assign wr_en      = (state == S_WRITE);

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = wtes_pkg::OP_DIV;
    ar_a      = UW'(esum);
    unique case (state)
      S_ROOT: begin
        cmd.start = 1'b1;
        cmd.op    = wtes_pkg::OP_SQRT;
        ar_a      = UW'(acc);
      end
      S_MEAN: begin
        cmd.start = 1'b1;
      end
      S_MSQ: begin
        cmd.start = 1'b1;
        ar_a      = UW'(ssum);
      end
      S_RMS: begin
        cmd.start = 1'b1;
        cmd.op    = wtes_pkg::OP_SQRT;
        ar_a      = UW'(acc);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (kind == wtes_pkg::KIND_DRONE_POS) && record_ok) begin
          state_next = S_MUL;
        end
      end
      S_MUL:       state_next = S_ACC;
      S_ACC:       state_next = (idx == 2'd2) ? S_ROOT : S_MUL;
      S_ROOT:      state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: state_next = ar_done ? S_EVCHK : S_ROOT_WAIT;
      S_EVCHK:     state_next = (count >= win_len) ? S_EVRD : S_WMUL;
      S_EVRD:      state_next = S_EVMUL;
      S_EVMUL:     state_next = S_EVSUB;
      S_EVSUB:     state_next = S_EVCHK;
      S_WMUL:      state_next = S_WRITE;
      S_WRITE:     state_next = S_SCAN;
      S_SCAN:      state_next = (!scan_issue && !pend) ? S_MEAN : S_SCAN;
      S_MEAN:      state_next = S_MEAN_WAIT;
      S_MEAN_WAIT: state_next = ar_done ? S_MSQ : S_MEAN_WAIT;
      S_MSQ:       state_next = S_MSQ_WAIT;
      S_MSQ_WAIT:  state_next = ar_done ? S_RMS : S_MSQ_WAIT;
      S_RMS:       state_next = S_RMS_WAIT;
      S_RMS_WAIT:  state_next = ar_done ? S_DONE : S_RMS_WAIT;
      S_DONE:      state_next = (!out_valid || !out_stall) ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      trk_code  <= wtes_pkg::RST_TRACKING_MODE_CODE;
      rec_only  <= wtes_pkg::RST_RECORD_ONLY;
      wlen      <= wtes_pkg::RST_WINDOW_LENGTH;
      tgt_x     <= '0;
      tgt_y     <= '0;
      tgt_z     <= '0;
      seen      <= '0;
      in_trk    <= 1'b0;
      cur_mode  <= '0;
      head      <= '0;
      count     <= '0;
      esum      <= '0;
      ssum      <= '0;
      wmax      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          wtes_pkg::REG_TRACKING_MODE_CODE:   trk_code <= cfg_data[wtes_pkg::MODE_W-1:0];
          wtes_pkg::REG_RECORD_ONLY_TRACKING: rec_only <= cfg_data[0];
          wtes_pkg::REG_WINDOW_LENGTH:        wlen     <= cfg_data;
          default: begin
          end
        endcase
      end

      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              wtes_pkg::KIND_TARGET_POS: begin
                tgt_x   <= pos_x;
                tgt_y   <= pos_y;
                tgt_z   <= pos_z;
                seen[0] <= 1'b1;
              end
              wtes_pkg::KIND_DRONE_VEL: seen[1] <= 1'b1;
              wtes_pkg::KIND_TARGET_VEL: seen[2] <= 1'b1;
              wtes_pkg::KIND_MODE: begin
                if (mode_code != cur_mode) begin
                  cur_mode <= mode_code;
                  if ((mode_code == trk_code) && !in_trk) begin
                    in_trk <= 1'b1;
                    if (rec_only) begin
                      head  <= '0;
                      count <= '0;
                      esum  <= '0;
                      ssum  <= '0;
                      wmax  <= '0;
                    end
                  end else if ((mode_code != trk_code) && in_trk) begin
                    in_trk <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_EVSUB: begin
          esum  <= esum - SW'(old_e);
          ssum  <= ssum - SQW'(prod);
          head  <= head_inc;
          count <= count - CW'(1);
        end
        S_WRITE: begin
          count <= count + CW'(1);
          esum  <= esum + SW'(err_now);
          ssum  <= ssum + SQW'(prod);
          wmax  <= '0;
        end
        S_SCAN: begin
          if (pend && (rd_data > wmax)) begin
            wmax <= rd_data;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        drn_x <= pos_x;
        drn_y <= pos_y;
        drn_z <= pos_z;
        idx   <= 2'd0;
        acc   <= '0;
      end
      S_MUL: begin
        prod <= dsat ? '1 : mul_p;
      end
      S_ACC: begin
        acc <= acc_sum[64] ? '1 : acc_sum[63:0];
        idx <= idx + 2'd1;
      end
      S_ROOT_WAIT: begin
        if (ar_done) begin
          err_now <= (ar_res > UW'(wtes_pkg::ERR_MAX)) ? wtes_pkg::ERR_MAX : EW'(ar_res);
        end
      end
      S_EVMUL: begin
        prod  <= mul_p;
        old_e <= rd_data;
      end
      S_WMUL: begin
        prod <= mul_p;
      end
      S_WRITE: begin
        ptr    <= head;
        issued <= '0;
        pend   <= 1'b0;
      end
      S_SCAN: begin
        pend <= scan_issue;
        if (scan_issue) begin
          ptr    <= ptr_inc;
          issued <= issued + CW'(1);
        end
      end
      S_MEAN_WAIT: begin
        if (ar_done) begin
          mean_r <= EW'(ar_res);
        end
      end
      S_MSQ_WAIT: begin
        if (ar_done) begin
          acc <= 64'(ar_res);
        end
      end
      S_RMS_WAIT: begin
        if (ar_done) begin
          rms_r <= EW'(ar_res);
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          range_error  <= err_now;
          mean_error   <= mean_r;
          max_error    <= wmax;
          rms_error    <= rms_r;
          sample_count <= wtes_pkg::CNT_OUT_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  wtes_ring #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata (err_now),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  wtes_arith #(
    .UW (UW),
    .CW (CW)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .a    (ar_a),
    .b    (count),
    .done (ar_done),
    .res  (ar_res)
  );

endmodule

>>> sim/wtes_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking error statistics checker
// Watches the input, output and register ports of the tracking error block.
// It keeps its own copy of the window, flags and mode, works out the
// statistics for every recorded drone position and compares each output
// transfer with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wtes_stats_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [wtes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wtes_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [wtes_pkg::KIND_W-1:0]     kind,
  input  logic signed [23:0]              pos_x,
  input  logic signed [23:0]              pos_y,
  input  logic signed [23:0]              pos_z,
  input  logic [wtes_pkg::MODE_W-1:0]     mode_code,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [wtes_pkg::ERR_W-1:0]      range_error,
  input  logic [wtes_pkg::ERR_W-1:0]      mean_error,
  input  logic [wtes_pkg::ERR_W-1:0]      max_error,
  input  logic [wtes_pkg::ERR_W-1:0]      rms_error,
  input  logic [wtes_pkg::CNT_OUT_W-1:0]  sample_count,
  output int                              fail_count,
  output int                              pending
);

  localparam int WIN_DEPTH = wtes_pkg::DEF_MAX_WINDOW;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic [wtes_pkg::ERR_W-1:0]     err;
    logic [wtes_pkg::ERR_W-1:0]     mean;
    logic [wtes_pkg::ERR_W-1:0]     peak;
    logic [wtes_pkg::ERR_W-1:0]     rms;
    logic [wtes_pkg::CNT_OUT_W-1:0] count;
  } window_stats_t;

  window_stats_t exp_fifo [EXP_DEPTH];
  int            exp_wr;
  int            exp_rd;
  int            exp_count;
  logic          exp_lost;

  logic [wtes_pkg::MODE_W-1:0] track_code;
  logic                        record_only;
  logic [wtes_pkg::CFG_W-1:0]  win_len;

  logic [wtes_pkg::ERR_W-1:0]  err_ring [WIN_DEPTH];
  int unsigned                 head;
  int unsigned                 count;
  longint unsigned             err_sum;
  longint unsigned             sq_sum;
  longint signed               tgt [3];
  logic [2:0]                  seen;
  logic                        tracking;
  logic [wtes_pkg::MODE_W-1:0] mode_now;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned diff_sq(longint signed a, longint signed b);
    longint unsigned d;
    d = (a >= b) ? longint'(a - b) : longint'(b - a);
    return d * d;
  endfunction

  task automatic clear_window();
    head = 0;
    count = 0;
    err_sum = 0;
    sq_sum = 0;
  endtask

  task automatic record_distance(longint signed x, longint signed y, longint signed z);
    longint unsigned sq;
    longint unsigned err_now;
    longint unsigned old;
    int unsigned     lim;
    logic [wtes_pkg::ERR_W-1:0] peak;
    window_stats_t   s;
    sq = diff_sq(x, tgt[0]) + diff_sq(y, tgt[1]) + diff_sq(z, tgt[2]);
    err_now = floor_sqrt(sq);
    if (err_now > wtes_pkg::ERR_MAX) err_now = wtes_pkg::ERR_MAX;
    lim = win_len;
    if (lim == 0) lim = 1;
    if (lim > WIN_DEPTH) lim = WIN_DEPTH;
    while (count >= lim) begin
      old = err_ring[head];
      err_sum -= old;
      sq_sum -= old * old;
      head = (head + 1) % WIN_DEPTH;
      count--;
    end
    err_ring[(head + count) % WIN_DEPTH] = err_now[wtes_pkg::ERR_W-1:0];
    count++;
    err_sum += err_now;
    sq_sum += err_now * err_now;
    peak = '0;
    for (int i = 0; i < count; i++)
      if (err_ring[(head + i) % WIN_DEPTH] > peak) peak = err_ring[(head + i) % WIN_DEPTH];
    s.err   = err_now[wtes_pkg::ERR_W-1:0];
    s.mean  = wtes_pkg::ERR_W'(err_sum / count);
    s.peak  = peak;
    s.rms   = wtes_pkg::ERR_W'(floor_sqrt(sq_sum / count));
    s.count = wtes_pkg::CNT_OUT_W'(count);
    if (exp_count < EXP_DEPTH) begin
      exp_fifo[exp_wr] = s;
      exp_wr = (exp_wr + 1) % EXP_DEPTH;
      exp_count++;
    end else begin
      exp_lost = 1'b1;
    end
  endtask

  task automatic track_event();
    case (kind)
      wtes_pkg::KIND_TARGET_POS: begin
        tgt[0] = pos_x;
        tgt[1] = pos_y;
        tgt[2] = pos_z;
        seen[0] = 1'b1;
      end
      wtes_pkg::KIND_DRONE_VEL: seen[1] = 1'b1;
      wtes_pkg::KIND_TARGET_VEL: seen[2] = 1'b1;
      wtes_pkg::KIND_MODE: begin
        if (mode_code != mode_now) begin
          mode_now = mode_code;
          if (mode_code == track_code && !tracking) begin
            tracking = 1'b1;
            if (record_only) clear_window();
          end
          if (mode_code != track_code && tracking) tracking = 1'b0;
        end
      end
      wtes_pkg::KIND_DRONE_POS: begin
        if (!(record_only && !tracking) && seen == 3'b111)
          record_distance(pos_x, pos_y, pos_z);
      end
      default: ;
    endcase
  endtask

  assign pending = exp_count + int'(exp_lost);

  always @(posedge clk) begin
    if (rst) begin
      track_code  = wtes_pkg::RST_TRACKING_MODE_CODE;
      record_only = wtes_pkg::RST_RECORD_ONLY;
      win_len     = wtes_pkg::RST_WINDOW_LENGTH;
      clear_window();
      tgt[0] = 0;
      tgt[1] = 0;
      tgt[2] = 0;
      seen = '0;
      tracking = 1'b0;
      mode_now = '0;
      exp_wr = 0;
      exp_rd = 0;
      exp_count = 0;
      exp_lost = 1'b0;
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          wtes_pkg::REG_TRACKING_MODE_CODE:   track_code = cfg_data[wtes_pkg::MODE_W-1:0];
          wtes_pkg::REG_RECORD_ONLY_TRACKING: record_only = cfg_data[0];
          wtes_pkg::REG_WINDOW_LENGTH:        win_len = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (exp_count == 0) begin
          if (fail_count < 10)
            $display("Output transfer with no prediction waiting: error %0d mean %0d",
                     range_error, mean_error);
          fail_count <= fail_count + 1;
        end else begin
          window_stats_t e;
          e = exp_fifo[exp_rd];
          exp_rd = (exp_rd + 1) % EXP_DEPTH;
          exp_count--;
          if (e.err !== range_error || e.mean !== mean_error || e.peak !== max_error ||
              e.rms !== rms_error || e.count !== sample_count) begin
            if (fail_count < 10)
              $display("Mismatch: expected err %0d mean %0d max %0d rms %0d count %0d, %s",
                       e.err, e.mean, e.peak, e.rms, e.count,
                       $sformatf("got %0d %0d %0d %0d %0d", range_error, mean_error,
                                 max_error, rms_error, sample_count));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) track_event();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking error statistics testbench
// Drives events into the tracking error block through a series of register
// settings, with random gaps and output stalls, and reports the verdict from
// the checker that runs beside the block.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 1400;
  localparam int PHASES     = 7;
  localparam int PHASE_ITEMS = 62;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [wtes_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wtes_pkg::CFG_W-1:0]      cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [wtes_pkg::KIND_W-1:0]     kind;
  logic signed [23:0]              pos_x;
  logic signed [23:0]              pos_y;
  logic signed [23:0]              pos_z;
  logic [wtes_pkg::MODE_W-1:0]     mode_code;
  logic                            out_valid;
  logic                            out_stall;
  logic [wtes_pkg::ERR_W-1:0]      range_error;
  logic [wtes_pkg::ERR_W-1:0]      mean_error;
  logic [wtes_pkg::ERR_W-1:0]      max_error;
  logic [wtes_pkg::ERR_W-1:0]      rms_error;
  logic [wtes_pkg::CNT_OUT_W-1:0]  sample_count;
  int                              fail_count;
  int                              pending;
  logic                            hold_now;
  int                              idle_cycles;
  logic signed [23:0]              tgt_x, tgt_y, tgt_z;

  windowed_tracking_error_stats i_dut (.*);

  wtes_stats_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  run;
    bit  st;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        out_stall <= 1'b0;
        run = 0;
      end else if (run == 0) begin
        st = ($urandom_range(0, 2) == 0);
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 4);
        if ($urandom_range(0, 7) == 0) begin
          st = 1'b0;
          run = $urandom_range(50, 150);
        end
        out_stall <= st;
      end else begin
        run--;
      end
    end
  end

  task automatic send_event(logic [wtes_pkg::KIND_W-1:0] k, logic signed [23:0] x,
                            logic signed [23:0] y, logic signed [23:0] z,
                            logic [wtes_pkg::MODE_W-1:0] m);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    pos_x     <= x;
    pos_y     <= y;
    pos_z     <= z;
    mode_code <= m;
    if (k == wtes_pkg::KIND_TARGET_POS) begin
      tgt_x = x;
      tgt_y = y;
      tgt_z = z;
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_mode(logic [wtes_pkg::MODE_W-1:0] m);
    send_event(wtes_pkg::KIND_MODE, 24'($urandom), 24'($urandom), 24'($urandom), m);
  endtask

  task automatic send_drone(logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z);
    send_event(wtes_pkg::KIND_DRONE_POS, x, y, z, 8'($urandom));
  endtask

  task automatic send_random(logic [wtes_pkg::MODE_W-1:0] tcode);
    int r;
    int sel;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if ($urandom_range(0, 9) < 7)
        send_drone(24'(tgt_x + $signed($urandom_range(0, 4000)) - 2000),
                   24'(tgt_y + $signed($urandom_range(0, 4000)) - 2000),
                   24'(tgt_z + $signed($urandom_range(0, 4000)) - 2000));
      else
        send_drone(24'($urandom), 24'($urandom), 24'($urandom));
    end else if (r < 65) begin
      if ($urandom_range(0, 9) < 6)
        send_event(wtes_pkg::KIND_TARGET_POS,
                   24'($signed($urandom_range(0, 200000)) - 100000),
                   24'($signed($urandom_range(0, 200000)) - 100000),
                   24'($signed($urandom_range(0, 200000)) - 100000), 8'($urandom));
      else
        send_event(wtes_pkg::KIND_TARGET_POS, 24'($urandom), 24'($urandom), 24'($urandom),
                   8'($urandom));
    end else if (r < 73) begin
      send_event(wtes_pkg::KIND_DRONE_VEL, 24'($urandom), 24'($urandom), 24'($urandom),
                 8'($urandom));
    end else if (r < 81) begin
      send_event(wtes_pkg::KIND_TARGET_VEL, 24'($urandom), 24'($urandom), 24'($urandom),
                 8'($urandom));
    end else if (r < 96) begin
      sel = $urandom_range(0, 9);
      send_mode(sel < 5 ? tcode : sel < 8 ? 8'($urandom_range(0, 5)) : 8'($urandom));
    end else begin
      send_event(3'($urandom_range(5, 7)), 24'($urandom), 24'($urandom), 24'($urandom),
                 8'($urandom));
    end
  endtask

  task automatic write_reg(logic [wtes_pkg::CFG_IDX_W-1:0] idx,
                           logic [wtes_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [wtes_pkg::CFG_W-1:0]  win_tab  [PHASES];
    logic [wtes_pkg::MODE_W-1:0] code_tab [PHASES];
    logic                        only_tab [PHASES];
    win_tab  = '{11'd16, 11'd4, 11'd0, 11'd2047, 11'd1, 11'd1024, 11'd7};
    code_tab = '{8'd255, 8'd0, 8'd42, 8'd3, 8'd128, 8'd7, 8'd3};
    only_tab = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    kind      <= '0;
    pos_x     <= '0;
    pos_y     <= '0;
    pos_z     <= '0;
    mode_code <= '0;
    hold_now  <= 1'b0;
    tgt_x = 0;
    tgt_y = 0;
    tgt_z = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_drone(24'sd5, 24'sd5, 24'sd5);
    send_event(3'd5, '1, '1, '1, '1);
    send_event(3'd6, '0, '0, '0, '0);
    send_event(3'd7, 24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 8'hA5);
    send_mode(wtes_pkg::RST_TRACKING_MODE_CODE);
    send_drone(24'sd1, 24'sd2, 24'sd3);
    send_event(wtes_pkg::KIND_TARGET_POS, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 8'd0);
    send_event(wtes_pkg::KIND_DRONE_VEL, '0, '0, '0, '0);
    send_drone(24'sd0, 24'sd0, 24'sd0);
    send_event(wtes_pkg::KIND_TARGET_VEL, '0, '0, '0, '0);
    send_drone(24'sh800000, 24'sh800000, 24'sh800000);
    send_drone(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_mode(wtes_pkg::RST_TRACKING_MODE_CODE);
    send_drone(24'sd0, 24'sh7FFFFF, 24'sh800000);
    send_mode(8'd255);
    send_drone(24'sd3, 24'sd4, 24'sd0);
    send_mode(wtes_pkg::RST_TRACKING_MODE_CODE);
    send_drone(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFF0);
    send_event(wtes_pkg::KIND_TARGET_POS, 24'sd0, 24'sd0, 24'sd0, 8'd0);
    send_drone(24'sd3, 24'sd4, 24'sd12);
    send_drone(-24'sd3, -24'sd4, -24'sd12);
    send_mode(8'd0);
    send_drone(24'sd1, 24'sd1, 24'sd1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(wtes_pkg::REG_TRACKING_MODE_CODE, wtes_pkg::CFG_W'(code_tab[p]));
      write_reg(wtes_pkg::REG_RECORD_ONLY_TRACKING, wtes_pkg::CFG_W'(only_tab[p]));
      write_reg(wtes_pkg::REG_WINDOW_LENGTH, win_tab[p]);
      cfg_write <= 1'b0;
      if (p == 1) hold_now <= 1'b1;
      @(posedge clk);
      hold_now <= 1'b0;
      send_mode(code_tab[p] + 8'd1);
      send_mode(code_tab[p]);
      send_event(wtes_pkg::KIND_TARGET_POS,
                 24'($signed($urandom_range(0, 200000)) - 100000),
                 24'($signed($urandom_range(0, 200000)) - 100000),
                 24'($signed($urandom_range(0, 200000)) - 100000), 8'($urandom));
      send_event(wtes_pkg::KIND_DRONE_VEL, 24'($urandom), 24'($urandom), 24'($urandom),
                 8'($urandom));
      send_event(wtes_pkg::KIND_TARGET_VEL, 24'($urandom), 24'($urandom), 24'($urandom),
                 8'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) send_random(code_tab[p]);
      drain();
    end

    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
